// File: rtl/pfm_pkg.sv
// ---------------------------------------------------------------------------
// pfm_pkg: shared types and constants of the page frame manager
// Handle store geometry, request and status codes, controller/datapath links.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package pfm_pkg;

  localparam int HANDLE_DEPTH = 32;
  localparam int HIDX_W       = 5;
  localparam int STAMP_W      = 32;

  localparam int FRAMES_DEF     = 8;
  localparam int SWAP_SLOTS_DEF = 24;
  localparam int PAGE_BYTES_DEF = 256;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_WRITE = 2'd3;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_SIZE_BIG   = 3'd1;
  localparam logic [2:0] ST_NO_HANDLE  = 3'd2;
  localparam logic [2:0] ST_BAD_HANDLE = 3'd3;
  localparam logic [2:0] ST_BAD_OFFSET = 3'd4;

  typedef enum logic [1:0] {
    FSEL_FREE,
    FSEL_RDATA,
    FSEL_ZERO
  } fsel_e;

  typedef struct packed {
    logic       latch_req;
    logic       scan_clear;
    logic       scan_step;
    logic       rd_victim;
    logic       frame_load;
    fsel_e      frame_sel;
    logic       set_evict;
    logic       commit;
    logic       load_out;
    logic [2:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_free;
    logic size_big;
    logic handle_bad;
    logic offset_bad;
    logic resident;
    logic scan_last;
    logic fh_found;
    logic ff_found;
    logic v_found;
  } stat_t;

endpackage
`default_nettype wire

// File: rtl/page_frame_manager_lru_top.sv
// ---------------------------------------------------------------------------
// page_frame_manager_lru_top: page frame manager with LRU replacement
// Allocate, free, read and write requests; issues swap-out and swap-in.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o carries func, handle, offset and
//   request_size; a transfer happens when valid is high and stall is low.
//   Output channel out_valid_o / out_stall_i carries one result per request.
//   Size, handle and offset errors go from check straight to commit; free
//   and resident reads and writes first load the frame of the handle.
//   Allocate and non-resident accesses scan the handle table and frame
//   map one entry a cycle over max(handles, FRAMES) entries, then pass
//   drain, decide and commit, with a victim-frame step when a page is
//   evicted. The scan, one handle per cycle through the stamp memory read
//   port, is the longest part of a request. One request is in flight at a time.
//   The result sits in an output register, so the next request is taken
//   while a result waits; a further result holds until the receiver drops
//   stall. Reset clears all handles and frames and sets the stamp to one;
//   no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module page_frame_manager_lru_top #(
  parameter int FRAMES     = pfm_pkg::FRAMES_DEF,
  parameter int SWAP_SLOTS = pfm_pkg::SWAP_SLOTS_DEF,
  parameter int PAGE_BYTES = pfm_pkg::PAGE_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  func_i,
  input  wire logic [4:0]  handle_i,
  input  wire logic [7:0]  offset_i,
  input  wire logic [15:0] request_size_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       status_o,
  output logic [4:0]       result_handle_o,
  output logic [10:0]      byte_address_o,
  output logic             evict_valid_o,
  output logic [4:0]       evict_handle_o,
  output logic [2:0]       evict_frame_o,
  output logic             evict_writeback_o,
  output logic             load_valid_o,
  output logic [2:0]       load_frame_o
);

  pfm_pkg::cmd_t  cmd;
  pfm_pkg::stat_t stat;

  pfm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  pfm_datapath #(
    .FRAMES     (FRAMES),
    .SWAP_SLOTS (SWAP_SLOTS),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .func_i            (func_i),
    .handle_i          (handle_i),
    .offset_i          (offset_i),
    .request_size_i    (request_size_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .status_o          (status_o),
    .result_handle_o   (result_handle_o),
    .byte_address_o    (byte_address_o),
    .evict_valid_o     (evict_valid_o),
    .evict_handle_o    (evict_handle_o),
    .evict_frame_o     (evict_frame_o),
    .evict_writeback_o (evict_writeback_o),
    .load_valid_o      (load_valid_o),
    .load_frame_o      (load_frame_o)
  );

endmodule
`default_nettype wire

// File: rtl/pfm_ctrl.sv
// ---------------------------------------------------------------------------
// pfm_ctrl: request sequencer
// Steps each request through checks, table scan, frame choice and commit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pfm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  input  wire pfm_pkg::stat_t stat_i,
  output pfm_pkg::cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_USEH   = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_DRAIN  = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_USEV   = 4'd6;
  localparam logic [3:0] S_COMMIT = 4'd7;

  logic [3:0] state_q, state_d;
  logic [2:0] status_q, status_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    cmd_o.frame_sel = pfm_pkg::FSEL_ZERO;
    cmd_o.out_status = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_req = 1'b1;
          status_d = pfm_pkg::ST_OK;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.scan_clear = 1'b1;
        priority if (stat_i.is_alloc && stat_i.size_big) begin
          status_d = pfm_pkg::ST_SIZE_BIG;
          state_d  = S_COMMIT;
        end else if (stat_i.is_alloc) begin
          state_d = S_SCAN;
        end else if (stat_i.handle_bad) begin
          status_d = pfm_pkg::ST_BAD_HANDLE;
          state_d  = S_COMMIT;
        end else if (stat_i.is_free) begin
          state_d = S_USEH;
        end else if (stat_i.offset_bad) begin
          status_d = pfm_pkg::ST_BAD_OFFSET;
          state_d  = S_COMMIT;
        end else if (stat_i.resident) begin
          state_d = S_USEH;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_USEH: begin
        // frame of the request handle was read during the check cycle
        cmd_o.frame_load = 1'b1;
        cmd_o.frame_sel  = pfm_pkg::FSEL_RDATA;
        state_d = S_COMMIT;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        cmd_o.rd_victim = 1'b1;
        priority if (stat_i.is_alloc && !stat_i.fh_found) begin
          status_d = pfm_pkg::ST_NO_HANDLE;
          state_d  = S_COMMIT;
        end else if (stat_i.ff_found) begin
          cmd_o.frame_load = 1'b1;
          cmd_o.frame_sel  = pfm_pkg::FSEL_FREE;
          state_d = S_COMMIT;
        end else if (stat_i.v_found) begin
          state_d = S_USEV;
        end else begin
          cmd_o.frame_load = 1'b1;
          cmd_o.frame_sel  = pfm_pkg::FSEL_ZERO;
          state_d = S_COMMIT;
        end
      end
      S_USEV: begin
        cmd_o.frame_load = 1'b1;
        cmd_o.frame_sel  = pfm_pkg::FSEL_RDATA;
        cmd_o.set_evict  = 1'b1;
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd_o.commit   = (status_q == pfm_pkg::ST_OK);
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= pfm_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/pfm_datapath.sv
// ---------------------------------------------------------------------------
// pfm_datapath: handle tables, frame map, scan unit and result register
// Holds per-handle state, scans one handle a cycle and applies commits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pfm_datapath #(
  parameter int FRAMES     = pfm_pkg::FRAMES_DEF,
  parameter int SWAP_SLOTS = pfm_pkg::SWAP_SLOTS_DEF,
  parameter int PAGE_BYTES = pfm_pkg::PAGE_BYTES_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [1:0]    func_i,
  input  wire logic [4:0]    handle_i,
  input  wire logic [7:0]    offset_i,
  input  wire logic [15:0]   request_size_i,
  input  wire pfm_pkg::cmd_t cmd_i,
  output pfm_pkg::stat_t     stat_o,
  output logic [2:0]         status_o,
  output logic [4:0]         result_handle_o,
  output logic [10:0]        byte_address_o,
  output logic               evict_valid_o,
  output logic [4:0]         evict_handle_o,
  output logic [2:0]         evict_frame_o,
  output logic               evict_writeback_o,
  output logic               load_valid_o,
  output logic [2:0]         load_frame_o
);

  localparam int HW = pfm_pkg::HIDX_W;
  localparam int HD = pfm_pkg::HANDLE_DEPTH;
  localparam int SWD = pfm_pkg::STAMP_W;
  localparam int HL = (FRAMES + SWAP_SLOTS < HD) ? FRAMES + SWAP_SLOTS : HD;
  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int SCAN_LEN = (HL > FRAMES) ? HL : FRAMES;
  localparam int IW = $clog2(SCAN_LEN + 1);

  logic [1:0]   func_q;
  logic [HW-1:0] h_q;
  logic [7:0]   off_q;
  logic [15:0]  size_q;

  logic [HD-1:0]     in_use_q, res_q, dirty_q;
  logic [FRAMES-1:0] fiu_q;
  logic [SWD-1:0]    ctr_q;

  logic [FW-1:0]  frame_mem [HD];
  logic [SWD-1:0] stamp_mem [HD];
  logic [FW-1:0]  frame_rd_q;
  logic [SWD-1:0] stamp_rd_q;

  logic [IW-1:0]  idx_q;
  logic [HW-1:0]  idx_h;
  logic [FW-1:0]  idx_f;
  logic           idx_in_h, idx_in_f;
  logic           cand_v_q;
  logic [HW-1:0]  cand_h_q;
  logic           fh_found_q, ff_found_q, v_found_q;
  logic [HW-1:0]  fh_q, v_q;
  logic [FW-1:0]  ff_q;
  logic [SWD-1:0] best_q;

  logic [FW-1:0]  frame_q;
  logic           evict_q;
  logic [HW-1:0]  frame_rd_addr;
  logic           is_alloc, is_free, is_write;
  logic [HW-1:0]  tgt_h;
  logic [31:0]    addr_full;

  assign idx_h    = HW'(idx_q);
  assign idx_f    = FW'(idx_q);
  assign idx_in_h = (32'(idx_q) < 32'(HL));
  assign idx_in_f = (32'(idx_q) < 32'(FRAMES));
  assign is_alloc = (func_q == pfm_pkg::FUNC_ALLOC);
  assign is_free  = (func_q == pfm_pkg::FUNC_FREE);
  assign is_write = (func_q == pfm_pkg::FUNC_WRITE);
  assign tgt_h    = is_alloc ? fh_q : h_q;
  assign frame_rd_addr = cmd_i.rd_victim ? v_q : h_q;
  assign addr_full = 32'(frame_q) * 32'(PAGE_BYTES) + 32'(off_q);

  always_comb begin
    stat_o.is_alloc   = is_alloc;
    stat_o.is_free    = is_free;
    stat_o.size_big   = (32'(size_q) > 32'(PAGE_BYTES));
    stat_o.handle_bad = (32'(h_q) >= 32'(HL)) || !in_use_q[h_q];
    stat_o.offset_bad = (32'(off_q) >= 32'(PAGE_BYTES));
    stat_o.resident   = res_q[h_q];
    stat_o.scan_last  = (32'(idx_q) == 32'(SCAN_LEN - 1));
    stat_o.fh_found   = fh_found_q;
    stat_o.ff_found   = ff_found_q;
    stat_o.v_found    = v_found_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_req) begin
      func_q <= func_i;
      h_q    <= handle_i;
      off_q  <= offset_i;
      size_q <= request_size_i;
    end
  end

  // tables without reset: only read for in-use resident handles
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !is_free && (is_alloc || !res_q[h_q])) begin
      frame_mem[tgt_h] <= frame_q;
    end
    if (cmd_i.commit && !is_free) begin
      stamp_mem[tgt_h] <= ctr_q;
    end
    frame_rd_q <= frame_mem[frame_rd_addr];
    stamp_rd_q <= stamp_mem[idx_h];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      cand_v_q   <= 1'b0;
      fh_found_q <= 1'b0;
      ff_found_q <= 1'b0;
      v_found_q  <= 1'b0;
    end else begin
      cand_v_q <= cmd_i.scan_step && idx_in_h && in_use_q[idx_h] && res_q[idx_h];
      if (cmd_i.scan_clear) begin
        idx_q      <= '0;
        fh_found_q <= 1'b0;
        ff_found_q <= 1'b0;
        v_found_q  <= 1'b0;
      end else begin
        if (cmd_i.scan_step) begin
          idx_q <= idx_q + 1'b1;
          if (idx_in_h && !in_use_q[idx_h] && !fh_found_q) begin
            fh_found_q <= 1'b1;
          end
          if (idx_in_f && !fiu_q[idx_f] && !ff_found_q) begin
            ff_found_q <= 1'b1;
          end
        end
        // stamp read is registered, so it pairs with the candidate of the previous scan step
        if (cand_v_q && (!v_found_q || stamp_rd_q < best_q)) begin
          v_found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cand_h_q <= idx_h;
    if (cmd_i.scan_step) begin
      if (idx_in_h && !in_use_q[idx_h] && !fh_found_q) begin
        fh_q <= idx_h;
      end
      if (idx_in_f && !fiu_q[idx_f] && !ff_found_q) begin
        ff_q <= idx_f;
      end
    end
    if (!cmd_i.scan_clear && cand_v_q && (!v_found_q || stamp_rd_q < best_q)) begin
      v_q    <= cand_h_q;
      best_q <= stamp_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      evict_q <= 1'b0;
    end else if (cmd_i.latch_req) begin
      evict_q <= 1'b0;
    end else if (cmd_i.set_evict) begin
      evict_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.frame_load) begin
      unique case (cmd_i.frame_sel)
        pfm_pkg::FSEL_FREE:  frame_q <= ff_q;
        pfm_pkg::FSEL_RDATA: frame_q <= frame_rd_q;
        default:             frame_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      res_q    <= '0;
      dirty_q  <= '0;
      fiu_q    <= '0;
      ctr_q    <= SWD'(1);
    end else if (cmd_i.commit) begin
      if (is_free) begin
        if (res_q[h_q] && (32'(frame_q) < 32'(FRAMES))) begin
          fiu_q[frame_q] <= 1'b0;
        end
        in_use_q[h_q] <= 1'b0;
        res_q[h_q]    <= 1'b0;
        dirty_q[h_q]  <= 1'b0;
      end else begin
        if (evict_q) begin
          res_q[v_q]   <= 1'b0;
          dirty_q[v_q] <= 1'b0;
        end
        if ((is_alloc || !res_q[h_q]) && (32'(frame_q) < 32'(FRAMES))) begin
          fiu_q[frame_q] <= 1'b1;
        end
        in_use_q[tgt_h] <= 1'b1;
        res_q[tgt_h]    <= 1'b1;
        if (is_alloc || is_write) begin
          dirty_q[tgt_h] <= 1'b1;
        end
        if (ctr_q != '1) begin
          ctr_q <= ctr_q + 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_o          <= cmd_i.out_status;
      result_handle_o   <= '0;
      byte_address_o    <= '0;
      evict_valid_o     <= 1'b0;
      evict_handle_o    <= '0;
      evict_frame_o     <= '0;
      evict_writeback_o <= 1'b0;
      load_valid_o      <= 1'b0;
      load_frame_o      <= '0;
      if (!is_alloc) begin
        result_handle_o <= h_q;
      end
      if (cmd_i.out_status == pfm_pkg::ST_OK) begin
        if (is_alloc) begin
          result_handle_o <= fh_q;
        end
        if (!is_free) begin
          load_frame_o      <= 3'(frame_q);
          evict_valid_o     <= evict_q;
          evict_handle_o    <= evict_q ? v_q : '0;
          evict_frame_o     <= evict_q ? 3'(frame_q) : '0;
          evict_writeback_o <= evict_q && dirty_q[v_q];
        end
        if (!is_alloc && !is_free) begin
          byte_address_o <= addr_full[10:0];
          load_valid_o   <= !res_q[h_q];
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/pfm_checker.sv
// ---------------------------------------------------------------------------
// pfm_assertions: port-level checks of the page frame manager
// Watches the top-level ports and flags inconsistent results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pfm_assertions (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [2:0]  status_o,
  input wire logic        evict_valid_o,
  input wire logic [4:0]  evict_handle_o,
  input wire logic [2:0]  evict_frame_o,
  input wire logic        evict_writeback_o,
  input wire logic        load_valid_o
);

  // busy after a transfer
  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while previous one in progress");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(status_o)))
    else $error("stalled result changed");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= pfm_pkg::ST_BAD_OFFSET))
    else $error("status code out of range");

  a_error_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != pfm_pkg::ST_OK) |-> (!evict_valid_o && !load_valid_o))
    else $error("swap command on failed request");

  a_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !evict_valid_o) |->
      (evict_handle_o == 5'd0 && evict_frame_o == 3'd0 && !evict_writeback_o))
    else $error("eviction fields set without eviction");

endmodule

bind page_frame_manager_lru_top pfm_assertions u_pfm_assertions (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .status_o          (status_o),
  .evict_valid_o     (evict_valid_o),
  .evict_handle_o    (evict_handle_o),
  .evict_frame_o     (evict_frame_o),
  .evict_writeback_o (evict_writeback_o),
  .load_valid_o      (load_valid_o)
);
`default_nettype wire

// File: tb/sv/pfm_checker.sv
// ---------------------------------------------------------------------------
// pfm_checker: result predictor and scoreboard for the page frame manager
// Watches both channels, keeps its own handle and frame tables, predicts one
// result per accepted request and compares it field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module pfm_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [1:0]  func_i,
  input  wire logic [4:0]  handle_i,
  input  wire logic [7:0]  offset_i,
  input  wire logic [15:0] request_size_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [2:0]  status_i,
  input  wire logic [4:0]  result_handle_i,
  input  wire logic [10:0] byte_address_i,
  input  wire logic        evict_valid_i,
  input  wire logic [4:0]  evict_handle_i,
  input  wire logic [2:0]  evict_frame_i,
  input  wire logic        evict_writeback_i,
  input  wire logic        load_valid_i,
  input  wire logic [2:0]  load_frame_i,
  output int               errors_o,
  output int               pending_o,
  output int               results_o,
  output int               evictions_o
);

  localparam int HDEPTH  = pfm_pkg::HANDLE_DEPTH;
  localparam int NFRAMES = pfm_pkg::FRAMES_DEF;
  localparam int PBYTES  = pfm_pkg::PAGE_BYTES_DEF;
  localparam int NHANDLE =
    (pfm_pkg::FRAMES_DEF + pfm_pkg::SWAP_SLOTS_DEF) < HDEPTH ?
    (pfm_pkg::FRAMES_DEF + pfm_pkg::SWAP_SLOTS_DEF) : HDEPTH;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  rhandle;
    logic [10:0] addr;
    logic        ev_valid;
    logic [4:0]  ev_handle;
    logic [2:0]  ev_frame;
    logic        ev_wb;
    logic        ld_valid;
    logic [2:0]  ld_frame;
  } page_result_t;

  logic        in_use [HDEPTH];
  logic        resident [HDEPTH];
  logic        dirty [HDEPTH];
  logic [2:0]  hframe [HDEPTH];
  logic [31:0] stamp [HDEPTH];
  logic        frame_busy [NFRAMES];
  logic [31:0] stamp_ctr;
  page_result_t expected_q[$];

  function automatic logic [31:0] next_stamp();
    logic [31:0] s;
    s = stamp_ctr;
    if (stamp_ctr != 32'hFFFF_FFFF) stamp_ctr = stamp_ctr + 1;
    return s;
  endfunction

  // Lowest free frame, else steal the least recently used resident page.
  function automatic logic [2:0] claim_frame(inout page_result_t r);
    int victim;
    victim = -1;
    for (int f = 0; f < NFRAMES; f++)
      if (!frame_busy[f]) return 3'(f);
    for (int h = 0; h < NHANDLE; h++)
      if (in_use[h] && resident[h])
        if (victim < 0 || stamp[h] < stamp[victim]) victim = h;
    if (victim < 0) return 3'd0;
    r.ev_valid  = 1'b1;
    r.ev_handle = 5'(victim);
    r.ev_frame  = hframe[victim];
    r.ev_wb     = dirty[victim];
    resident[victim] = 1'b0;
    dirty[victim]    = 1'b0;
    return hframe[victim];
  endfunction

  function automatic page_result_t predict_request(logic [1:0] fn, logic [4:0] h,
                                                   logic [7:0] off, logic [15:0] sz);
    page_result_t r;
    logic [2:0] f;
    int nh;
    r = '0;
    if (fn == pfm_pkg::FUNC_ALLOC) begin
      if (sz > PBYTES) begin
        r.status = pfm_pkg::ST_SIZE_BIG;
        return r;
      end
      nh = NHANDLE;
      for (int i = NHANDLE - 1; i >= 0; i--) if (!in_use[i]) nh = i;
      if (nh >= NHANDLE) begin
        r.status = pfm_pkg::ST_NO_HANDLE;
        return r;
      end
      f = claim_frame(r);
      in_use[nh] = 1'b1;
      resident[nh] = 1'b1;
      hframe[nh] = f;
      dirty[nh] = 1'b1;
      stamp[nh] = next_stamp();
      frame_busy[f] = 1'b1;
      r.rhandle = 5'(nh);
      r.ld_frame = f;
      return r;
    end
    r.rhandle = h;
    if (h >= NHANDLE || !in_use[h]) begin
      r.status = pfm_pkg::ST_BAD_HANDLE;
      return r;
    end
    if (fn == pfm_pkg::FUNC_FREE) begin
      if (resident[h]) frame_busy[hframe[h]] = 1'b0;
      in_use[h] = 1'b0;
      resident[h] = 1'b0;
      dirty[h] = 1'b0;
      return r;
    end
    if (off >= PBYTES) begin
      r.status = pfm_pkg::ST_BAD_OFFSET;
      return r;
    end
    if (!resident[h]) begin
      f = claim_frame(r);
      frame_busy[f] = 1'b1;
      hframe[h] = f;
      resident[h] = 1'b1;
      r.ld_valid = 1'b1;
    end
    stamp[h] = next_stamp();
    if (fn == pfm_pkg::FUNC_WRITE) dirty[h] = 1'b1;
    r.addr = 11'(hframe[h] * PBYTES + off);
    r.ld_frame = hframe[h];
    return r;
  endfunction

  task automatic compare_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    page_result_t e;
    if (!rst_ni) begin
      for (int i = 0; i < HDEPTH; i++) begin
        in_use[i] = 0; resident[i] = 0; dirty[i] = 0; hframe[i] = 0; stamp[i] = 0;
      end
      for (int f = 0; f < NFRAMES; f++) frame_busy[f] = 0;
      stamp_ctr = 1;
      expected_q.delete();
      errors_o = 0;
      pending_o = 0;
      results_o = 0;
      evictions_o = 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        expected_q.push_back(predict_request(func_i, handle_i, offset_i, request_size_i));
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transfer, status %0d", $time, status_i);
          errors_o++;
        end else begin
          e = expected_q.pop_front();
          if (e.ev_valid) evictions_o++;
          compare_field("status", e.status, status_i);
          compare_field("result_handle", e.rhandle, result_handle_i);
          compare_field("byte_address", e.addr, byte_address_i);
          compare_field("evict_valid", e.ev_valid, evict_valid_i);
          compare_field("evict_handle", e.ev_handle, evict_handle_i);
          compare_field("evict_frame", e.ev_frame, evict_frame_i);
          compare_field("evict_writeback", e.ev_wb, evict_writeback_i);
          compare_field("load_valid", e.ld_valid, load_valid_i);
          compare_field("load_frame", e.ld_frame, load_frame_i);
        end
      end
      pending_o = expected_q.size();
    end
  end
endmodule

// File: tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench: page frame manager LRU stimulus and verdict
// Drives directed and random paging requests with random idling and a long
// output hold-off; the checker predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [1:0]  func;
  logic [4:0]  handle;
  logic [7:0]  offset;
  logic [15:0] req_size;
  logic        out_valid, out_stall;
  logic [2:0]  status, evict_frame, load_frame;
  logic [4:0]  result_handle, evict_handle;
  logic [10:0] byte_address;
  logic        evict_valid, evict_writeback, load_valid;
  int          errors, pending, results, evictions;
  int          send_idle_pct, recv_idle_pct;
  bit          hold_off;
  int          sent;

  page_frame_manager_lru_top DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .func_i(func), .handle_i(handle), .offset_i(offset), .request_size_i(req_size),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .result_handle_o(result_handle), .byte_address_o(byte_address),
    .evict_valid_o(evict_valid), .evict_handle_o(evict_handle),
    .evict_frame_o(evict_frame), .evict_writeback_o(evict_writeback),
    .load_valid_o(load_valid), .load_frame_o(load_frame)
  );

  pfm_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .func_i(func), .handle_i(handle), .offset_i(offset), .request_size_i(req_size),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .status_i(status), .result_handle_i(result_handle), .byte_address_i(byte_address),
    .evict_valid_i(evict_valid), .evict_handle_i(evict_handle),
    .evict_frame_i(evict_frame), .evict_writeback_i(evict_writeback),
    .load_valid_i(load_valid), .load_frame_i(load_frame),
    .errors_o(errors), .pending_o(pending), .results_o(results), .evictions_o(evictions)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: random stall, or a solid hold-off when asked.
  always @(negedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  task automatic send_request(logic [1:0] fn, logic [4:0] h, logic [7:0] off,
                              logic [15:0] sz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= fn;
    handle <= h;
    offset <= off;
    req_size <= sz;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Mostly valid accesses to a small working set so pages churn through frames.
  task automatic random_request();
    int r;
    logic [1:0] fn;
    logic [4:0] h;
    logic [7:0] off;
    logic [15:0] sz;
    r = $urandom_range(99);
    h = (r < 85) ? 5'($urandom_range(15)) : 5'($urandom);
    off = 8'($urandom);
    sz = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(256));
    if (r < 25) fn = pfm_pkg::FUNC_ALLOC;
    else if (r < 35) fn = pfm_pkg::FUNC_FREE;
    else if (r < 65) fn = pfm_pkg::FUNC_READ;
    else fn = pfm_pkg::FUNC_WRITE;
    send_request(fn, h, off, sz);
  endtask

  initial begin
    rst_n = 0;
    in_valid = 0;
    func = pfm_pkg::FUNC_ALLOC;
    handle = 0;
    offset = 0;
    req_size = 0;
    out_stall = 0;
    hold_off = 0;
    sent = 0;
    send_idle_pct = 13;
    recv_idle_pct = 57;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: error codes on an empty table, size extremes, access extremes.
    send_request(pfm_pkg::FUNC_READ, 5'd0, 8'd0, 16'd0);
    send_request(pfm_pkg::FUNC_FREE, 5'd31, 8'd0, 16'd0);
    send_request(pfm_pkg::FUNC_ALLOC, 5'd0, 8'd0, 16'hFFFF);
    send_request(pfm_pkg::FUNC_ALLOC, 5'd0, 8'd0, 16'd257);
    send_request(pfm_pkg::FUNC_ALLOC, 5'd0, 8'd0, 16'd256);
    send_request(pfm_pkg::FUNC_ALLOC, 5'd0, 8'd0, 16'd0);
    send_request(pfm_pkg::FUNC_READ, 5'd0, 8'd255, 16'd0);
    send_request(pfm_pkg::FUNC_WRITE, 5'd1, 8'd0, 16'hFFFF);
    send_request(pfm_pkg::FUNC_WRITE, 5'd31, 8'd255, 16'd0);
    send_request(pfm_pkg::FUNC_FREE, 5'd1, 8'd0, 16'd0);
    send_request(pfm_pkg::FUNC_FREE, 5'd1, 8'd0, 16'd0);

    // Fill every handle, hit no-handle-free, then touch evicted pages.
    for (int i = 0; i < 33; i++)
      send_request(pfm_pkg::FUNC_ALLOC, 5'd0, 8'($urandom), 16'd1);
    for (int i = 0; i < 32; i++)
      send_request((i % 2) ? pfm_pkg::FUNC_READ : pfm_pkg::FUNC_WRITE, 5'(i),
                   8'($urandom), 16'd0);
    for (int i = 0; i < 32; i++) send_request(pfm_pkg::FUNC_FREE, 5'(i), 8'd0, 16'd0);

    // Long receiver hold-off while the sender keeps offering.
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 12; i++) random_request();
    join

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 57 : 0;
      recv_idle_pct = (phase == 0) ? 57 : (phase == 1) ? 13 : 0;
      for (int i = 0; i < 180; i++) random_request();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d requests, checked %0d results, %0d with eviction.",
             sent, results, evictions);
    if (errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
